@@ sv/h1mp_pkg.sv @@
// Shared types, constants and the single-pass byte step logic of the HTTP/1.x parser.
// No dependencies.
package h1mp_pkg;

    localparam int LEN_W      = 32;
    localparam int MAX_RES    = 4;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int RES_CW     = $clog2(MAX_RES + 1);
    localparam int CFG_AW     = 3;

    localparam logic [CFG_AW-1:0] ADDR_PARSE_MODE = CFG_AW'(0);

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_STATUS  = 2'd1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [8*5-1:0]  LIT_HTTP  = "HTTP/";
    localparam logic [8*14-1:0] NAME_CL   = "content-length";
    localparam logic [8*17-1:0] NAME_TE   = "transfer-encoding";
    localparam logic [8*7-1:0]  VAL_CHUNK = "chunked";
    localparam logic [4:0] NAME_CL_LEN = 5'd14;
    localparam logic [4:0] NAME_TE_LEN = 5'd17;
    localparam logic [3:0] CHUNK_LEN   = 4'd7;
    localparam logic [4:0] NAME_DEAD   = 5'd31;
    localparam logic [3:0] VALUE_DEAD  = 4'd15;

    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_CHUNKED = 2'd2;
    localparam logic ERR_BAD_REQ = 1'b0;
    localparam logic ERR_VERSION = 1'b1;

    typedef enum logic [3:0] {
        EV_CONSUMED   = 4'd0,
        EV_REQ_BEGIN  = 4'd1,
        EV_STAT_BEGIN = 4'd2,
        EV_MSG_BEGIN  = 4'd3,
        EV_METHOD     = 4'd4,
        EV_TARGET     = 4'd5,
        EV_REASON     = 4'd6,
        EV_NAME       = 4'd7,
        EV_VALUE      = 4'd8,
        EV_HDR_DONE   = 4'd9,
        EV_HDRS_END   = 4'd10,
        EV_BODY       = 4'd11,
        EV_MSG_END    = 4'd12,
        EV_ERROR      = 4'd13
    } t_event;

    typedef enum logic [5:0] {
        S_IDLE   = 6'd0,  S_ERR    = 6'd1,  S_RQ_M0  = 6'd2,  S_RQ_M   = 6'd3,
        S_RQ_T0  = 6'd4,  S_RQ_T   = 6'd5,  S_RQ_09  = 6'd6,
        S_RQ_L0  = 6'd7,  S_RQ_L1  = 6'd8,  S_RQ_L2  = 6'd9,  S_RQ_L3  = 6'd10,
        S_RQ_L4  = 6'd11, S_RQ_MAJ = 6'd12, S_RQ_MIN = 6'd13, S_RQ_LF  = 6'd14,
        S_ST_L0  = 6'd15, S_ST_L1  = 6'd16, S_ST_L2  = 6'd17, S_ST_L3  = 6'd18,
        S_ST_L4  = 6'd19, S_ST_MAJ = 6'd20, S_ST_MIN = 6'd21, S_ST_C0  = 6'd22,
        S_ST_C   = 6'd23, S_ST_R0  = 6'd24, S_ST_R   = 6'd25, S_ST_LF  = 6'd26,
        S_HN0    = 6'd27, S_HN     = 6'd28, S_HCOL   = 6'd29, S_HV0    = 6'd30,
        S_HV     = 6'd31, S_HVLF   = 6'd32, S_HVEND  = 6'd33, S_HENDLF = 6'd34,
        S_LW0    = 6'd35, S_LWLF   = 6'd36, S_LWSP0  = 6'd37, S_LWSP   = 6'd38,
        S_BFIX   = 6'd39, S_BEND   = 6'd40, S_CK0    = 6'd41, S_CK     = 6'd42,
        S_CKLF1  = 6'd43, S_CKBODY = 6'd44, S_CKLF2  = 6'd45, S_CKCR3  = 6'd46,
        S_CKLF3  = 6'd47
    } t_st;

    typedef struct packed {
        t_st               st;
        t_st               lws_next;
        t_st               lws_empty;
        logic [7:0]        maj;
        logic [7:0]        min;
        logic [15:0]       code;
        logic [LEN_W-1:0]  rem;
        logic              len_known;
        logic              chunked;
        logic              vstarted;
        logic              ndead;
        logic [4:0]        nm0;
        logic [4:0]        nm1;
        logic [3:0]        vm;
        logic [LEN_W-1:0]  vnum;
    } t_pstate;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  b;
        logic [1:0]  kind;
        logic        err;
    } t_evt;

    typedef struct packed {
        t_pstate     s;
        logic        again;
        logic [1:0]  n;
        t_evt [2:0]  evs;
    } t_pass;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  b;
        logic [7:0]  maj;
        logic [7:0]  min;
        logic [15:0] code;
        logic [1:0]  kind;
        logic        err;
        logic        last;
    } t_res;

    function automatic logic [7:0] f_low(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic f_ctl(input logic [7:0] c);
        return c <= 8'd31 || c == CH_DEL;
    endfunction

    function automatic logic f_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic f_prn(input logic [7:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic logic f_txt(input logic [7:0] c);
        return !f_ctl(c) || c == CH_HT;
    endfunction

    function automatic logic f_ws(input logic [7:0] c);
        return c == CH_SP || c == CH_HT;
    endfunction

    function automatic logic f_tok(input logic [7:0] c);
        logic sep;
        case (c) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09, 8'h3F: sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return c <= 8'd127 && !f_ctl(c) && !sep;
    endfunction

    function automatic logic [4:0] f_hex(input logic [7:0] c);
        // bit 4 flags a valid hex digit
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else                               r = 5'd0;
        return r;
    endfunction

    function automatic logic [7:0] f_sat8(input logic [7:0] v, input logic [7:0] c);
        logic [11:0] t;
        t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {8'd0, 4'(c - 8'h30)};
        return (t > 12'd255) ? 8'hFF : t[7:0];
    endfunction

    function automatic logic [LEN_W-1:0] f_satlen(input logic [LEN_W-1:0] v,
                                                  input logic hex, input logic [3:0] d);
        logic [LEN_W+3:0] w;
        if (hex) w = ({4'd0, v} << 4) + {{LEN_W{1'b0}}, d};
        else     w = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{LEN_W{1'b0}}, d};
        return (w[LEN_W+3:LEN_W] != 4'd0) ? {LEN_W{1'b1}} : w[LEN_W-1:0];
    endfunction

    function automatic t_pass f_push(input t_pass p, input t_event e, input logic [7:0] b,
                                     input logic [1:0] k, input logic er);
        t_pass r;
        r = p;
        if (r.n != 2'd3) begin
            r.evs[r.n] = '{ev: e, b: b, kind: k, err: er};
            r.n = r.n + 2'd1;
        end
        return r;
    endfunction

    function automatic t_pass f_fail(input t_pass p, input logic er);
        t_pass r;
        r = f_push(p, EV_ERROR, 8'd0, KIND_PLAIN, er);
        r.s.st = S_ERR;
        return r;
    endfunction

    function automatic t_pass f_name(input t_pass p, input logic [7:0] c);
        t_pass r;
        logic [7:0] ch0, ch1;
        r = f_push(p, EV_NAME, c, KIND_PLAIN, ERR_BAD_REQ);
        ch0 = (r.s.nm0 < NAME_CL_LEN) ? NAME_CL[8*(13 - int'(r.s.nm0)) +: 8] : 8'd0;
        ch1 = (r.s.nm1 < NAME_TE_LEN) ? NAME_TE[8*(16 - int'(r.s.nm1)) +: 8] : 8'd0;
        if (r.s.nm0 < NAME_CL_LEN && f_low(c) == ch0) r.s.nm0 = r.s.nm0 + 5'd1;
        else                                          r.s.nm0 = NAME_DEAD;
        if (r.s.nm1 < NAME_TE_LEN && f_low(c) == ch1) r.s.nm1 = r.s.nm1 + 5'd1;
        else                                          r.s.nm1 = NAME_DEAD;
        return r;
    endfunction

    function automatic t_pass f_value(input t_pass p, input logic [7:0] c);
        t_pass r;
        logic [7:0] ch;
        r = f_push(p, EV_VALUE, c, KIND_PLAIN, ERR_BAD_REQ);
        ch = (r.s.vm < CHUNK_LEN) ? VAL_CHUNK[8*(6 - int'(r.s.vm)) +: 8] : 8'd0;
        if (r.s.vm < CHUNK_LEN && f_low(c) == ch) r.s.vm = r.s.vm + 4'd1;
        else                                      r.s.vm = VALUE_DEAD;
        if (!r.s.ndead) begin
            if (f_dig(c)) r.s.vnum = f_satlen(r.s.vnum, 1'b0, 4'(c - 8'h30));
            else          r.s.ndead = 1'b1;
        end
        return r;
    endfunction

    function automatic t_pass f_colon(input t_pass p);
        t_pass r;
        r = p;
        r.s.st = S_LW0;
        r.s.lws_next = S_HV0;
        r.s.lws_empty = S_HVEND;
        return r;
    endfunction

    function automatic t_pass f_finish(input t_pass p);
        t_pass r;
        r = f_push(p, EV_MSG_END, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
        r.s.st = S_IDLE;
        return r;
    endfunction

    // One state transition for one byte; again asks for another pass on the same byte.
    function automatic t_pass f_pass(input t_pstate s_in, input logic [7:0] c,
                                     input logic [1:0] mode);
        t_pass r;
        logic [4:0] hx;
        logic [2:0] li;
        logic verok;
        logic [LEN_W-1:0] dec;
        r.s = s_in;
        r.again = 1'b0;
        r.n = 2'd0;
        r.evs = '0;
        hx = f_hex(c);
        li = (s_in.st >= S_ST_L0) ? 3'(s_in.st - S_ST_L0) : 3'(s_in.st - S_RQ_L0);
        verok = (s_in.maj == 8'd0) ? (s_in.min == 8'd9) : (s_in.maj == 8'd1 && s_in.min <= 8'd1);
        dec = s_in.rem - LEN_W'(1);
        case (s_in.st)
            S_IDLE: begin
                r.s.len_known = 1'b0;
                r.s.chunked = 1'b0;
                r.s.rem = '0;
                r.s.maj = 8'd0;
                r.s.min = 8'd0;
                r.s.code = 16'd0;
                if (mode == MODE_REQUEST) r.s.st = S_RQ_M0;
                else if (mode == MODE_STATUS) r.s.st = S_ST_L0;
                else begin
                    r = f_push(r, EV_MSG_BEGIN, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                    r.s.st = S_HN0;
                end
                r.again = 1'b1;
            end
            S_RQ_L0, S_RQ_L1, S_RQ_L2, S_RQ_L3, S_RQ_L4,
            S_ST_L0, S_ST_L1, S_ST_L2, S_ST_L3, S_ST_L4: begin
                if (c == LIT_HTTP[8*(4 - int'(li)) +: 8]) r.s.st = t_st'(s_in.st + 6'd1);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_M0: begin
                if (f_tok(c)) begin
                    r = f_push(r, EV_METHOD, c, KIND_PLAIN, ERR_BAD_REQ);
                    r.s.st = S_RQ_M;
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_M: begin
                if (c == CH_SP) r.s.st = S_RQ_T0;
                else if (f_tok(c)) r = f_push(r, EV_METHOD, c, KIND_PLAIN, ERR_BAD_REQ);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_T0: begin
                if (f_prn(c)) begin
                    r = f_push(r, EV_TARGET, c, KIND_PLAIN, ERR_BAD_REQ);
                    r.s.st = S_RQ_T;
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_T: begin
                if (c == CH_SP) r.s.st = S_RQ_L0;
                else if (f_prn(c)) r = f_push(r, EV_TARGET, c, KIND_PLAIN, ERR_BAD_REQ);
                else if (c == CH_CR) r.s.st = S_RQ_09;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_09: begin
                if (c == CH_LF) begin
                    r.s.maj = 8'd0;
                    r.s.min = 8'd9;
                    r = f_push(r, EV_REQ_BEGIN, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                    r = f_push(r, EV_HDRS_END, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                    r = f_finish(r);
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_MAJ, S_ST_MAJ: begin
                if (c == CH_DOT) r.s.st = t_st'(s_in.st + 6'd1);
                else if (f_dig(c)) r.s.maj = f_sat8(s_in.maj, c);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_MIN: begin
                if (c == CH_CR) r.s.st = S_RQ_LF;
                else if (f_dig(c)) r.s.min = f_sat8(s_in.min, c);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_ST_MIN: begin
                if (c == CH_SP) r.s.st = S_ST_C0;
                else if (f_dig(c)) r.s.min = f_sat8(s_in.min, c);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_RQ_LF, S_ST_LF: begin
                if (c != CH_LF) r = f_fail(r, ERR_BAD_REQ);
                else if (!verok) r = f_fail(r, ERR_VERSION);
                else begin
                    r = f_push(r, (s_in.st == S_RQ_LF) ? EV_REQ_BEGIN : EV_STAT_BEGIN,
                               8'd0, KIND_PLAIN, ERR_BAD_REQ);
                    r.s.st = S_HN0;
                end
            end
            S_ST_C0: begin
                if (f_dig(c)) begin
                    r.s.st = S_ST_C;
                    r.again = 1'b1;
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_ST_C: begin
                if (f_dig(c)) begin
                    logic [19:0] t;
                    t = ({4'd0, s_in.code} << 3) + ({4'd0, s_in.code} << 1)
                        + {16'd0, 4'(c - 8'h30)};
                    r.s.code = (t > 20'd65535) ? 16'hFFFF : t[15:0];
                end else if (c == CH_SP) r.s.st = S_ST_R0;
                else if (c == CH_CR) r.s.st = S_ST_LF;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_ST_R0: begin
                if (f_txt(c)) begin
                    r = f_push(r, EV_REASON, c, KIND_PLAIN, ERR_BAD_REQ);
                    r.s.st = S_ST_R;
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_ST_R: begin
                if (f_txt(c)) r = f_push(r, EV_REASON, c, KIND_PLAIN, ERR_BAD_REQ);
                else if (c == CH_CR) r.s.st = S_ST_LF;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_HN0: begin
                if (f_tok(c)) begin
                    r.s.nm0 = 5'd0;
                    r.s.nm1 = 5'd0;
                    r.s.vm = 4'd0;
                    r.s.vstarted = 1'b0;
                    r.s.vnum = '0;
                    r.s.ndead = 1'b0;
                    r = f_name(r, c);
                    r.s.st = S_HN;
                end else if (c == CH_CR) r.s.st = S_HENDLF;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_HN: begin
                if (f_tok(c)) r = f_name(r, c);
                else if (c == CH_COLON) r = f_colon(r);
                else if (c == CH_CR) begin
                    r.s.st = S_LWLF;
                    r.s.lws_next = S_HCOL;
                    r.s.lws_empty = S_ERR;
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_HCOL: begin
                if (c == CH_COLON) r = f_colon(r);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_LW0: begin
                if (c == CH_CR) r.s.st = S_LWLF;
                else if (f_ws(c)) r.s.st = S_LWSP;
                else if (f_prn(c)) begin
                    r.s.st = s_in.lws_next;
                    r.again = 1'b1;
                end else r = f_fail(r, ERR_BAD_REQ);
            end
            S_LWLF: begin
                if (c == CH_LF) r.s.st = S_LWSP0;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_LWSP0: begin
                if (f_ws(c)) begin
                    if (s_in.vstarted) begin
                        r = f_value(r, CH_CR);
                        r = f_value(r, CH_LF);
                        r = f_value(r, c);
                    end
                    r.s.st = S_LWSP;
                end else if (s_in.lws_empty == S_ERR) r = f_fail(r, ERR_BAD_REQ);
                else begin
                    r.s.st = s_in.lws_empty;
                    r.again = 1'b1;
                end
            end
            S_LWSP: begin
                if (f_ws(c)) begin
                    if (s_in.vstarted) r = f_value(r, c);
                end else begin
                    r.s.st = s_in.lws_next;
                    r.again = 1'b1;
                end
            end
            S_HV0: begin
                if (f_txt(c)) begin
                    r.s.vstarted = 1'b1;
                    r = f_value(r, c);
                    r.s.st = S_HV;
                end else if (c == CH_CR) r.s.st = S_HVLF;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_HV: begin
                if (c == CH_CR) begin
                    r.s.st = S_LWLF;
                    r.s.lws_next = S_HV;
                    r.s.lws_empty = S_HVEND;
                end else if (f_txt(c)) r = f_value(r, c);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_HVLF: begin
                if (c == CH_LF) r.s.st = S_HVEND;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_HVEND: begin
                if (s_in.nm0 == NAME_CL_LEN) begin
                    r.s.len_known = 1'b1;
                    r.s.rem = s_in.vnum;
                    r = f_push(r, EV_HDR_DONE, 8'd0, KIND_LENGTH, ERR_BAD_REQ);
                end else if (s_in.nm1 == NAME_TE_LEN && s_in.vm == CHUNK_LEN) begin
                    r.s.chunked = 1'b1;
                    r = f_push(r, EV_HDR_DONE, 8'd0, KIND_CHUNKED, ERR_BAD_REQ);
                end else begin
                    r = f_push(r, EV_HDR_DONE, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                end
                r.s.st = S_HN0;
                r.again = 1'b1;
            end
            S_HENDLF: begin
                if (c != CH_LF) r = f_fail(r, ERR_BAD_REQ);
                else begin
                    r = f_push(r, EV_HDRS_END, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                    if (s_in.chunked) r.s.st = S_CK0;
                    else if (s_in.len_known && s_in.rem != '0) r.s.st = S_BFIX;
                    else if (!s_in.len_known && mode >= 2'd2) r.s.st = S_BEND;
                    else r = f_finish(r);
                end
            end
            S_BFIX: begin
                r = f_push(r, EV_BODY, c, KIND_PLAIN, ERR_BAD_REQ);
                if (s_in.rem != '0) r.s.rem = dec;
                if (r.s.rem == '0) r = f_finish(r);
            end
            S_BEND: begin
                r = f_push(r, EV_BODY, c, KIND_PLAIN, ERR_BAD_REQ);
            end
            S_CK0: begin
                if (!hx[4]) r = f_fail(r, ERR_BAD_REQ);
                else begin
                    r.s.rem = '0;
                    r.s.st = S_CK;
                    r.again = 1'b1;
                end
            end
            S_CK: begin
                if (c == CH_CR) r.s.st = S_CKLF1;
                else if (hx[4]) r.s.rem = f_satlen(s_in.rem, 1'b1, hx[3:0]);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_CKLF1: begin
                if (c == CH_LF) r.s.st = (s_in.rem != '0) ? S_CKBODY : S_CKCR3;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_CKBODY: begin
                if (s_in.rem != '0) begin
                    r = f_push(r, EV_BODY, c, KIND_PLAIN, ERR_BAD_REQ);
                    r.s.rem = dec;
                end else if (c == CH_CR) r.s.st = S_CKLF2;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_CKLF2: begin
                if (c == CH_LF) r.s.st = S_CK0;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_CKCR3: begin
                if (c == CH_CR) r.s.st = S_CKLF3;
                else r = f_fail(r, ERR_BAD_REQ);
            end
            S_CKLF3: begin
                if (c == CH_LF) r = f_finish(r);
                else r = f_fail(r, ERR_BAD_REQ);
            end
            default: r = f_fail(r, ERR_BAD_REQ);
        endcase
        return r;
    endfunction

endpackage

@@ sv/h1mp_cfg.sv @@
// APB-style register port holding the parse mode.
// Depends on h1mp_pkg.
module h1mp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [h1mp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [1:0]                  o_mode
);
    import h1mp_pkg::*;

    logic [1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
        end else if (psel && penable && pwrite && paddr == ADDR_PARSE_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign prdata = (paddr == ADDR_PARSE_MODE) ? {30'd0, r_mode} : 32'd0;
    assign pready = 1'b1;
    assign o_mode = r_mode;
endmodule

@@ sv/h1mp_step.sv @@
// Byte step: up to three chained state passes for one byte, packed into result slots.
// Depends on h1mp_pkg.
module h1mp_step (
    input  h1mp_pkg::t_pstate                     i_state,
    input  logic [7:0]                            i_byte,
    input  logic [1:0]                            i_mode,
    output h1mp_pkg::t_pstate                     o_state,
    output h1mp_pkg::t_res [h1mp_pkg::MAX_RES-1:0] o_res,
    output logic [h1mp_pkg::RES_CW-1:0]           o_cnt
);
    import h1mp_pkg::*;

    t_pass pa, pb, pc;

    always_comb begin
        pa = f_pass(i_state, i_byte, i_mode);
        if (pa.again) begin
            pb = f_pass(pa.s, i_byte, i_mode);
        end else begin
            pb = '0;
            pb.s = pa.s;
        end
        if (pb.again) begin
            pc = f_pass(pb.s, i_byte, i_mode);
        end else begin
            pc = '0;
            pc.s = pb.s;
        end
    end

    always_comb begin
        o_res = '0;
        o_cnt = '0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < pa.n && o_cnt < RES_CW'(MAX_RES)) begin
                o_res[o_cnt[1:0]].ev   = pa.evs[i].ev;
                o_res[o_cnt[1:0]].b    = pa.evs[i].b;
                o_res[o_cnt[1:0]].kind = pa.evs[i].kind;
                o_res[o_cnt[1:0]].err  = pa.evs[i].err;
                o_cnt = o_cnt + RES_CW'(1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < pb.n && o_cnt < RES_CW'(MAX_RES)) begin
                o_res[o_cnt[1:0]].ev   = pb.evs[i].ev;
                o_res[o_cnt[1:0]].b    = pb.evs[i].b;
                o_res[o_cnt[1:0]].kind = pb.evs[i].kind;
                o_res[o_cnt[1:0]].err  = pb.evs[i].err;
                o_cnt = o_cnt + RES_CW'(1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < pc.n && o_cnt < RES_CW'(MAX_RES)) begin
                o_res[o_cnt[1:0]].ev   = pc.evs[i].ev;
                o_res[o_cnt[1:0]].b    = pc.evs[i].b;
                o_res[o_cnt[1:0]].kind = pc.evs[i].kind;
                o_res[o_cnt[1:0]].err  = pc.evs[i].err;
                o_cnt = o_cnt + RES_CW'(1);
            end
        end
        if (o_cnt == '0) begin
            o_res[0].ev = EV_CONSUMED;
            o_cnt = RES_CW'(1);
        end
        for (int i = 0; i < MAX_RES; i++) begin
            o_res[i].maj  = pc.s.maj;
            o_res[i].min  = pc.s.min;
            o_res[i].code = pc.s.code;
            o_res[i].last = (RES_CW'(i + 1) == o_cnt);
        end
    end

    assign o_state = pc.s;
endmodule

@@ sv/h1mp_res_fifo.sv @@
// Result queue: takes up to MAX_RES results per cycle, delivers one per transaction.
// Depends on h1mp_pkg.
module h1mp_res_fifo (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  h1mp_pkg::t_res [h1mp_pkg::MAX_RES-1:0] i_res,
    input  logic [h1mp_pkg::RES_CW-1:0]            i_push_cnt,
    output logic                                   o_room,
    output logic [h1mp_pkg::FIFO_CW-1:0]           o_count,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output h1mp_pkg::t_res                         o_res
);
    import h1mp_pkg::*;

    t_res                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_CW-1:0]   r_cnt;
    logic                 pop;

    assign pop     = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign o_room  = (r_cnt <= FIFO_CW'(FIFO_DEPTH - MAX_RES));
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (RES_CW'(k) < i_push_cnt) begin
                r_mem[r_wr + FIFO_AW'(k)] <= i_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(i_push_cnt);
            r_rd  <= r_rd + FIFO_AW'(pop);
            r_cnt <= r_cnt + FIFO_CW'(i_push_cnt) - FIFO_CW'(pop);
        end
    end
endmodule

@@ sv/http1_message_parser.sv @@
// HTTP/1.x message parser top level: input register, byte step, parser state, result queue.
// Depends on h1mp_pkg, h1mp_cfg, h1mp_step, h1mp_res_fifo.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------------
//   input    | i_in_valid / o_in_ready   | i_func, i_data_byte
//   result   | o_out_valid / i_out_ready | o_event_res, o_out_byte, o_version_major,
//            |                           | o_version_minor, o_status_code, o_header_kind,
//            |                           | o_error_code, o_last
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A byte accepted into the input register is parsed from there (up to three chained state
// passes) once the queue has room; its 0 to 4 results enter an 8-entry queue, which offers
// them one per cycle while the result receiver is ready.
// Sustained rate is one byte per cycle while each byte yields one result and the receiver
// is ready; the single result port sets it when bytes yield more.
// The step stalls while the queue has fewer than 4 free slots. Reset is synchronous.
module http1_message_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [3:0]                  o_event_res,
    output logic [7:0]                  o_out_byte,
    output logic [7:0]                  o_version_major,
    output logic [7:0]                  o_version_minor,
    output logic [15:0]                 o_status_code,
    output logic [1:0]                  o_header_kind,
    output logic                        o_error_code,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [h1mp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import h1mp_pkg::*;

    logic                r_in_vld, r_in_func;
    logic [7:0]          r_in_byte;
    t_pstate             r_state, n_state, step_state;
    t_res [MAX_RES-1:0]  step_res;
    logic [RES_CW-1:0]   step_cnt, push_cnt;
    logic [1:0]          mode;
    logic                room, fire;
    logic [FIFO_CW-1:0]  fifo_count;
    t_res                head;

    h1mp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode)
    );

    h1mp_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_mode  (mode),
        .o_state (step_state),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    assign fire       = r_in_vld && room;
    assign o_in_ready = !r_in_vld || fire;

    always_comb begin
        n_state  = r_state;
        push_cnt = '0;
        if (fire) begin
            if (r_in_func) begin
                n_state.st = S_IDLE;
            end else if (r_state.st != S_ERR) begin
                n_state  = step_state;
                push_cnt = step_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_state  <= '{st: S_IDLE, lws_next: t_st'(6'd0), lws_empty: t_st'(6'd0),
                          default: '0};
        end else begin
            if (o_in_ready) r_in_vld <= i_in_valid;
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func <= i_func;
            r_in_byte <= i_data_byte;
        end
    end

    h1mp_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (step_res),
        .i_push_cnt (push_cnt),
        .o_room     (room),
        .o_count    (fifo_count),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (head)
    );

    assign o_event_res     = head.ev;
    assign o_out_byte      = head.b;
    assign o_version_major = head.maj;
    assign o_version_minor = head.min;
    assign o_status_code   = head.code;
    assign o_header_kind   = head.kind;
    assign o_error_code    = head.err;
    assign o_last          = head.last;

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_func) |=> (r_state.st == S_IDLE))
        else $error("restart did not return to message start");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_state.st == S_ERR) |-> (push_cnt == '0))
        else $error("results pushed in error state");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt != '0) |-> step_res[2'(push_cnt - RES_CW'(1))].last)
        else $error("final result of a byte not marked last");
endmodule

@@ dv/testbench.sv @@
// Testbench for http1_message_parser: streams HTTP/1.x bytes in all parse modes and checks
// every result against a cycle-free predictor of the parser. Depends on h1mp_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
    import h1mp_pkg::*;

    localparam logic [1:0] MODE_HEADERS = 2'd2;
    localparam logic [1:0] MODE_ALT     = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_event_res;
    logic [7:0]  o_out_byte, o_version_major, o_version_minor;
    logic [15:0] o_status_code;
    logic [1:0]  o_header_kind;
    logic        o_error_code, o_last;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    http1_message_parser dut (.*);

    always #4 i_clk = ~i_clk;

    // parser shadow state
    logic [1:0]  mode;
    t_st         pst, lws_nxt, lws_emp;
    logic [7:0]  ver_maj, ver_min;
    logic [15:0] code;
    logic [31:0] remain, val_num;
    logic        have_len, is_chunked, val_begun, num_frozen;
    logic [4:0]  nm_pos [2];
    logic [3:0]  val_pos;

    t_res        step_res [MAX_RES];
    int          step_n;
    t_res        events_due [$];
    logic [7:0]  msg_q [$];

    int          fails = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          send_busy_run = 0, recv_busy_run = 0, hold_req = 0;

    function automatic logic is_ctl(logic [7:0] c);
        return c <= 8'd31 || c == 8'd127;
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_prn(logic [7:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic logic is_txt(logic [7:0] c);
        return !is_ctl(c) || c == CH_HT;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SP || c == CH_HT;
    endfunction

    function automatic logic is_tok(logic [7:0] c);
        string seps;
        seps = "()<>@,;:\\\"/[]={} \t?";
        if (c > 8'd127 || is_ctl(c)) return 1'b0;
        for (int i = 0; i < seps.len(); i++) if (c == seps[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (is_dig(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] fold_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [31:0] grow_len(logic [31:0] v, int base, int d);
        longint unsigned t;
        t = longint'(v) * base + d;
        return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic logic [7:0] grow_ver(logic [7:0] v, logic [7:0] c);
        int t;
        t = v * 10 + (c - "0");
        return (t > 255) ? 8'hFF : t[7:0];
    endfunction

    function automatic void post(t_event e, logic [7:0] b, logic [1:0] k, logic er);
        if (step_n >= MAX_RES) return;
        step_res[step_n] = '{ev: e, b: b, maj: ver_maj, min: ver_min, code: code,
                             kind: k, err: er, last: 1'b0};
        step_n++;
    endfunction

    function automatic void trip(logic er);
        post(EV_ERROR, 8'd0, KIND_PLAIN, er);
        pst = S_ERR;
    endfunction

    function automatic void take_name(logic [7:0] c);
        string names [2];
        names[0] = "content-length";
        names[1] = "transfer-encoding";
        post(EV_NAME, c, KIND_PLAIN, ERR_BAD_REQ);
        for (int k = 0; k < 2; k++) begin
            if (nm_pos[k] < names[k].len() && fold_lower(c) == names[k][nm_pos[k]])
                nm_pos[k] = nm_pos[k] + 5'd1;
            else
                nm_pos[k] = NAME_DEAD;
        end
    endfunction

    function automatic void take_value(logic [7:0] c);
        string chunk_word;
        chunk_word = "chunked";
        post(EV_VALUE, c, KIND_PLAIN, ERR_BAD_REQ);
        if (val_pos < CHUNK_LEN && fold_lower(c) == chunk_word[val_pos])
            val_pos = val_pos + 4'd1;
        else val_pos = VALUE_DEAD;
        if (!num_frozen) begin
            if (is_dig(c)) val_num = grow_len(val_num, 10, c - "0");
            else num_frozen = 1'b1;
        end
    endfunction

    function automatic void end_msg();
        pst = S_IDLE;
        post(EV_MSG_END, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
    endfunction

    function automatic void shadow_reset();
        mode = MODE_REQUEST;
        pst = S_IDLE; lws_nxt = S_IDLE; lws_emp = S_IDLE;
        ver_maj = 0; ver_min = 0; code = 0; remain = 0; val_num = 0;
        have_len = 0; is_chunked = 0; val_begun = 0; num_frozen = 0;
        nm_pos[0] = 0; nm_pos[1] = 0; val_pos = 0;
    endfunction

    // Predict the results of one accepted transaction and queue them.
    function automatic void predict_byte(logic f, logic [7:0] c);
        bit again;
        t_st s;
        int idx, h;
        string lit;
        lit = "HTTP/";
        step_n = 0;
        if (f) begin
            pst = S_IDLE;
            return;
        end
        if (pst == S_ERR) return;
        again = 1;
        for (int it = 0; it < 8 && again; it++) begin
            s = pst;
            again = 0;
            if ((s >= S_RQ_L0 && s <= S_RQ_L4) || (s >= S_ST_L0 && s <= S_ST_L4)) begin
                idx = (s >= S_ST_L0) ? s - S_ST_L0 : s - S_RQ_L0;
                if (c == lit[idx]) pst = t_st'(s + 1);
                else trip(ERR_BAD_REQ);
            end else case (s)
                S_IDLE: begin
                    have_len = 0; is_chunked = 0; remain = 0;
                    ver_maj = 0; ver_min = 0; code = 0;
                    if (mode == MODE_REQUEST) pst = S_RQ_M0;
                    else if (mode == MODE_STATUS) pst = S_ST_L0;
                    else begin
                        post(EV_MSG_BEGIN, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                        pst = S_HN0;
                    end
                    again = 1;
                end
                S_RQ_M0:
                    if (is_tok(c)) begin
                        post(EV_METHOD, c, KIND_PLAIN, ERR_BAD_REQ);
                        pst = S_RQ_M;
                    end else trip(ERR_BAD_REQ);
                S_RQ_M:
                    if (c == CH_SP) pst = S_RQ_T0;
                    else if (is_tok(c)) post(EV_METHOD, c, KIND_PLAIN, ERR_BAD_REQ);
                    else trip(ERR_BAD_REQ);
                S_RQ_T0:
                    if (is_prn(c)) begin
                        post(EV_TARGET, c, KIND_PLAIN, ERR_BAD_REQ);
                        pst = S_RQ_T;
                    end else trip(ERR_BAD_REQ);
                S_RQ_T:
                    if (c == CH_SP) pst = S_RQ_L0;
                    else if (is_prn(c)) post(EV_TARGET, c, KIND_PLAIN, ERR_BAD_REQ);
                    else if (c == CH_CR) pst = S_RQ_09;
                    else trip(ERR_BAD_REQ);
                S_RQ_09:
                    if (c == CH_LF) begin
                        ver_maj = 0; ver_min = 9;
                        post(EV_REQ_BEGIN, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                        post(EV_HDRS_END, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                        end_msg();
                    end else trip(ERR_BAD_REQ);
                S_RQ_MAJ, S_ST_MAJ:
                    if (c == CH_DOT) pst = t_st'(s + 1);
                    else if (is_dig(c)) ver_maj = grow_ver(ver_maj, c);
                    else trip(ERR_BAD_REQ);
                S_RQ_MIN, S_ST_MIN:
                    if (s == S_RQ_MIN && c == CH_CR) pst = S_RQ_LF;
                    else if (s == S_ST_MIN && c == CH_SP) pst = S_ST_C0;
                    else if (is_dig(c)) ver_min = grow_ver(ver_min, c);
                    else trip(ERR_BAD_REQ);
                S_RQ_LF, S_ST_LF:
                    if (c != CH_LF) trip(ERR_BAD_REQ);
                    else if (!(ver_maj == 0 ? ver_min == 9 : (ver_maj == 1 && ver_min <= 1)))
                        trip(ERR_VERSION);
                    else begin
                        post(s == S_RQ_LF ? EV_REQ_BEGIN : EV_STAT_BEGIN, 8'd0,
                             KIND_PLAIN, ERR_BAD_REQ);
                        pst = S_HN0;
                    end
                S_ST_C0:
                    if (is_dig(c)) begin
                        pst = S_ST_C;
                        again = 1;
                    end else trip(ERR_BAD_REQ);
                S_ST_C:
                    if (is_dig(c)) begin
                        h = code * 10 + (c - "0");
                        code = (h > 65535) ? 16'hFFFF : h[15:0];
                    end else if (c == CH_SP) pst = S_ST_R0;
                    else if (c == CH_CR) pst = S_ST_LF;
                    else trip(ERR_BAD_REQ);
                S_ST_R0:
                    if (is_txt(c)) begin
                        post(EV_REASON, c, KIND_PLAIN, ERR_BAD_REQ);
                        pst = S_ST_R;
                    end else trip(ERR_BAD_REQ);
                S_ST_R:
                    if (is_txt(c)) post(EV_REASON, c, KIND_PLAIN, ERR_BAD_REQ);
                    else if (c == CH_CR) pst = S_ST_LF;
                    else trip(ERR_BAD_REQ);
                S_HN0:
                    if (is_tok(c)) begin
                        nm_pos[0] = 0; nm_pos[1] = 0; val_pos = 0;
                        val_begun = 0; val_num = 0; num_frozen = 0;
                        take_name(c);
                        pst = S_HN;
                    end else if (c == CH_CR) pst = S_HENDLF;
                    else trip(ERR_BAD_REQ);
                S_HN:
                    if (is_tok(c)) take_name(c);
                    else if (c == CH_COLON) begin
                        pst = S_LW0; lws_nxt = S_HV0; lws_emp = S_HVEND;
                    end else if (c == CH_CR) begin
                        pst = S_LWLF; lws_nxt = S_HCOL; lws_emp = S_ERR;
                    end else trip(ERR_BAD_REQ);
                S_HCOL:
                    if (c == CH_COLON) begin
                        pst = S_LW0; lws_nxt = S_HV0; lws_emp = S_HVEND;
                    end else trip(ERR_BAD_REQ);
                S_LW0:
                    if (c == CH_CR) pst = S_LWLF;
                    else if (is_ws(c)) pst = S_LWSP;
                    else if (is_prn(c)) begin
                        pst = lws_nxt;
                        again = 1;
                    end else trip(ERR_BAD_REQ);
                S_LWLF:
                    if (c == CH_LF) pst = S_LWSP0;
                    else trip(ERR_BAD_REQ);
                S_LWSP0:
                    if (is_ws(c)) begin
                        if (val_begun) begin
                            take_value(CH_CR); take_value(CH_LF); take_value(c);
                        end
                        pst = S_LWSP;
                    end else if (lws_emp == S_ERR) trip(ERR_BAD_REQ);
                    else begin
                        pst = lws_emp;
                        again = 1;
                    end
                S_LWSP:
                    if (is_ws(c)) begin
                        if (val_begun) take_value(c);
                    end else begin
                        pst = lws_nxt;
                        again = 1;
                    end
                S_HV0:
                    if (is_txt(c)) begin
                        val_begun = 1;
                        take_value(c);
                        pst = S_HV;
                    end else if (c == CH_CR) pst = S_HVLF;
                    else trip(ERR_BAD_REQ);
                S_HV:
                    if (c == CH_CR) begin
                        pst = S_LWLF; lws_nxt = S_HV; lws_emp = S_HVEND;
                    end else if (is_txt(c)) take_value(c);
                    else trip(ERR_BAD_REQ);
                S_HVLF:
                    if (c == CH_LF) pst = S_HVEND;
                    else trip(ERR_BAD_REQ);
                S_HVEND: begin
                    if (nm_pos[0] == NAME_CL_LEN) begin
                        have_len = 1; remain = val_num;
                        post(EV_HDR_DONE, 8'd0, KIND_LENGTH, ERR_BAD_REQ);
                    end else if (nm_pos[1] == NAME_TE_LEN && val_pos == CHUNK_LEN) begin
                        is_chunked = 1;
                        post(EV_HDR_DONE, 8'd0, KIND_CHUNKED, ERR_BAD_REQ);
                    end else post(EV_HDR_DONE, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                    pst = S_HN0;
                    again = 1;
                end
                S_HENDLF:
                    if (c != CH_LF) trip(ERR_BAD_REQ);
                    else begin
                        post(EV_HDRS_END, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
                        if (is_chunked) pst = S_CK0;
                        else if (have_len && remain != 0) pst = S_BFIX;
                        else if (!have_len && mode >= MODE_HEADERS) pst = S_BEND;
                        else end_msg();
                    end
                S_BFIX: begin
                    post(EV_BODY, c, KIND_PLAIN, ERR_BAD_REQ);
                    if (remain != 0) remain--;
                    if (remain == 0) end_msg();
                end
                S_BEND: post(EV_BODY, c, KIND_PLAIN, ERR_BAD_REQ);
                S_CK0:
                    if (hex_digit(c) < 0) trip(ERR_BAD_REQ);
                    else begin
                        remain = 0;
                        pst = S_CK;
                        again = 1;
                    end
                S_CK: begin
                    h = hex_digit(c);
                    if (c == CH_CR) pst = S_CKLF1;
                    else if (h >= 0) remain = grow_len(remain, 16, h);
                    else trip(ERR_BAD_REQ);
                end
                S_CKLF1:
                    if (c == CH_LF) pst = (remain != 0) ? S_CKBODY : S_CKCR3;
                    else trip(ERR_BAD_REQ);
                S_CKBODY:
                    if (remain != 0) begin
                        post(EV_BODY, c, KIND_PLAIN, ERR_BAD_REQ);
                        remain--;
                    end else if (c == CH_CR) pst = S_CKLF2;
                    else trip(ERR_BAD_REQ);
                S_CKLF2:
                    if (c == CH_LF) pst = S_CK0;
                    else trip(ERR_BAD_REQ);
                S_CKCR3:
                    if (c == CH_CR) pst = S_CKLF3;
                    else trip(ERR_BAD_REQ);
                S_CKLF3:
                    if (c == CH_LF) end_msg();
                    else trip(ERR_BAD_REQ);
                default: trip(ERR_BAD_REQ);
            endcase
        end
        if (step_n == 0) post(EV_CONSUMED, 8'd0, KIND_PLAIN, ERR_BAD_REQ);
        step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) events_due.push_back(step_res[i]);
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{ev: t_event'(o_event_res), b: o_out_byte, maj: o_version_major,
                    min: o_version_minor, code: o_status_code, kind: o_header_kind,
                    err: o_error_code, last: o_last};
            if (events_due.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %p", $time, got);
                fails++;
            end else begin
                want = events_due.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p, actual %p", $time, want, got);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result receiver with random stalls and an occasional long hold-off
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end
            if ($urandom_range(0, 19) == 0) recv_busy_run = ($urandom_range(0, 2) == 0);
            gap = recv_busy_run ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic f, input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 19) == 0) send_busy_run = ($urandom_range(0, 2) == 0);
        gap = send_busy_run ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(f, b);
        items_sent++;
    endtask

    task automatic send_msg();
        foreach (msg_q[i]) send_item(1'b0, msg_q[i]);
        msg_q.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endtask

    function automatic string mix_case(input string s);
        for (int i = 0; i < s.len(); i++)
            if (((s[i] >= "a" && s[i] <= "z") || (s[i] >= "A" && s[i] <= "Z")) && $urandom_range(0, 1))
                s[i] = s[i] ^ 8'h20;
        return s;
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_PARSE_MODE; pwdata <= {30'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mode = m;
    endtask

    // One random message in the current mode; mostly well formed, sometimes damaged.
    task automatic random_msg();
        int n, len, kind;
        bit lenhdr, chunk, damaged;
        lenhdr = 0; chunk = 0; len = 0;
        if (mode == MODE_REQUEST) begin
            n = $urandom_range(1, 4);
            repeat (n) msg_q.push_back($urandom_range("A", "Z"));
            put_str(" /");
            repeat ($urandom_range(0, 3)) msg_q.push_back($urandom_range(8'h21, 8'h7E));
            if ($urandom_range(0, 5) == 0) put_str("\r\n");
            else begin
                case ($urandom_range(0, 5))
                    0: put_str(" HTTP/1.0\r\n");
                    1: put_str(" HTTP/0.9\r\n");
                    2: put_str($sformatf(" HTTP/%0d.%0d\r\n", $urandom_range(0, 300),
                                         $urandom_range(0, 12)));
                    default: put_str(" HTTP/1.1\r\n");
                endcase
            end
        end else if (mode == MODE_STATUS) begin
            put_str($sformatf("HTTP/1.%0d %0d", $urandom_range(0, 1), $urandom_range(0, 999)));
            if ($urandom_range(0, 1)) put_str(" OK\tfine");
            put_str("\r\n");
        end
        if (!(mode == MODE_REQUEST && msg_q[msg_q.size() - 1] == CH_LF
              && msg_q[msg_q.size() - 3] != "/" && msg_q.size() < 12 && 0)) begin
            repeat ($urandom_range(0, 1)) begin
                kind = $urandom_range(0, 4);
                case (kind)
                    0: begin
                        len = $urandom_range(0, 6);
                        lenhdr = 1;
                        put_str({mix_case("Content-Length"), ": ", $sformatf("%0d", len)});
                        if ($urandom_range(0, 3) == 0) put_str("x9");
                        put_str("\r\n");
                    end
                    1: begin
                        chunk = 1;
                        put_str({mix_case("Transfer-Encoding"), ":\t", mix_case("chunked"),
                                 "\r\n"});
                    end
                    2: put_str("X-a:\r\n two\r\n\tmore\r\n");
                    3: put_str("Host : b\r\n");
                    default: put_str({mix_case("Transfer-Encodin"), ": x\r\n"});
                endcase
            end
            put_str("\r\n");
            if (chunk) begin
                repeat ($urandom_range(1, 2)) begin
                    n = $urandom_range(1, 3);
                    put_str($sformatf("%0h\r\n", n));
                    repeat (n) msg_q.push_back($urandom_range(0, 255));
                    put_str("\r\n");
                end
                put_str("0\r\n\r\n");
            end else if (lenhdr)
                repeat (len) msg_q.push_back($urandom_range(0, 255));
            else if (mode >= MODE_HEADERS)
                repeat ($urandom_range(0, 4)) msg_q.push_back($urandom_range(0, 255));
        end
        damaged = ($urandom_range(0, 4) == 0);
        if (damaged) msg_q[$urandom_range(0, msg_q.size() - 1)] = $urandom_range(0, 255);
        send_msg();
        if (damaged || mode >= MODE_HEADERS || $urandom_range(0, 3) == 0)
            send_item(1'b1, $urandom_range(0, 255));
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_msg();
    endtask

    task automatic test_request_line();
        set_mode(MODE_REQUEST);
        put_str("GET /a HTTP/1.1\r\ncontent-LENGTH: 99999999999\r\n\r\n");
        send_msg();
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, "a");
        send_item(1'b1, 8'h00);
        random_phase(10);
    endtask

    task automatic test_status_line();
        set_mode(MODE_STATUS);
        put_str("HTTP/1.0 99999 \tR\r\n\r\n");
        send_msg();
        random_phase(10);
    endtask

    task automatic test_headers_only();
        set_mode(MODE_HEADERS);
        random_phase(10);
        set_mode(MODE_ALT);
        random_phase(10);
    endtask

    task automatic test_backpressure();
        set_mode(MODE_REQUEST);
        hold_req = 1;
        send_busy_run = 1;
        put_str("GET / HTTP/1.1\r\n\r\n");
        send_msg();
        send_busy_run = 0;
    endtask

    initial begin
        shadow_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_request_line();
        test_status_line();
        test_headers_only();
        test_backpressure();
        drain();
        if (fails == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
